// ===== src/rtcdc_pkg.sv =====
// Package for the RTC calendar converter: widths, request codes and the
// constant year and month start tables. No dependencies.
`default_nettype none
package rtcdc_pkg;
    localparam int DAY_BITS  = 15;
    localparam int BASE_YEAR = 1900;
    localparam int DAY_SHIFT = 17;
    localparam int YEAR_CNT  = 256;
    localparam logic [3:0] MONTH_MAX = 4'd11;

    typedef enum logic {
        REQ_ENCODE = 1'b0,
        REQ_DECODE = 1'b1
    } t_req;

    typedef logic [16:0] t_ystart_tab [YEAR_CNT];
    typedef logic        t_leap_tab [YEAR_CNT];
    typedef logic [8:0]  t_mstart_tab [2][13];

    function automatic logic leap_of(input int unsigned y);
        return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    function automatic t_ystart_tab build_ystart();
        t_ystart_tab t;
        int unsigned s;
        s = 0;
        for (int y = 0; y < YEAR_CNT; y++) begin
            t[y] = 17'(s);
            s = s + (leap_of(y + BASE_YEAR) ? 366 : 365);
        end
        return t;
    endfunction

    function automatic t_leap_tab build_leap();
        t_leap_tab t;
        for (int y = 0; y < YEAR_CNT; y++) begin
            t[y] = leap_of(y + BASE_YEAR);
        end
        return t;
    endfunction

    localparam t_ystart_tab YEAR_START = build_ystart();
    localparam t_leap_tab   YEAR_LEAP  = build_leap();
    localparam t_mstart_tab MONTH_START = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
          9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274,
          9'd305, 9'd335, 9'd366}
    };
endpackage
`default_nettype wire

// ===== src/rtc_day_count_calendar_convert_core.sv =====
// Each accepted transaction is registered through Stage 1 to Stage 4 to its result.
// Throughput: one transaction per cycle; the whole pipeline holds while
// the output is stalled. Year lookups use constant tables, not loops.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on rtcdc_pkg.
`default_nettype none
module rtc_day_count_calendar_convert_core
    import rtcdc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_req_type,
    input  wire  [6:0]  i_year_in,
    input  wire  [7:0]  i_month_in,
    input  wire  [4:0]  i_mday_in,
    input  wire  [4:0]  i_hour_in,
    input  wire  [5:0]  i_minute_in,
    input  wire  [5:0]  i_second_in,
    input  wire  [31:0] i_word_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_word_out,
    output logic [6:0]  o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_mday_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic        o_day_overflow
);
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_en    = !(r_v4 && i_stall);
    assign o_stall = r_v4 && i_stall;
    assign o_valid = r_v4;

    // Stage 1
    logic        r1_dec;
    logic [7:0]  r1_year;
    logic [3:0]  r1_mon;
    logic [4:0]  r1_md;
    logic [16:0] r1_tod;
    logic [14:0] r1_d;
    logic [15:0] w_qprod;
    logic [4:0]  w_q;
    logic [26:0] w_yprod;
    logic [14:0] w_din;

    assign w_qprod = 16'(i_month_in) * 16'd171;
    assign w_q     = w_qprod[15:11];
    assign w_din   = i_word_in[DAY_SHIFT +: DAY_BITS];
    assign w_yprod = 27'(w_din) * 27'd2871;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dec <= i_req_type;
            r1_md  <= i_mday_in;
            r1_d   <= w_din;
            if (i_req_type == REQ_ENCODE) begin
                r1_year <= 8'(i_year_in) + 8'(w_q);
                r1_mon  <= 4'(i_month_in - 8'(w_q) * 8'd12);
                r1_tod  <= {i_hour_in, i_minute_in, i_second_in};
            end else begin
                r1_year <= {1'b0, w_yprod[26:20]};
                r1_mon  <= '0;
                r1_tod  <= i_word_in[16:0];
            end
        end
    end

    // Stage 2
    logic        r2_dec;
    logic [16:0] r2_a;
    logic [8:0]  r2_ms;
    logic [7:0]  r2_year;
    logic [4:0]  r2_md;
    logic [16:0] r2_tod;
    logic [14:0] r2_d;
    logic [7:0]  w_yp1, w_ym1, w_ysel;

    assign w_yp1 = r1_year + 8'd1;
    assign w_ym1 = r1_year - 8'd1;
    always_comb begin
        if (17'(r1_d) >= YEAR_START[w_yp1]) begin
            w_ysel = w_yp1;
        end else if (17'(r1_d) >= YEAR_START[r1_year]) begin
            w_ysel = r1_year;
        end else begin
            w_ysel = w_ym1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dec <= r1_dec;
            r2_md  <= r1_md;
            r2_tod <= r1_tod;
            r2_d   <= r1_d;
            r2_ms  <= MONTH_START[YEAR_LEAP[r1_year]][r1_mon];
            if (r1_dec == REQ_ENCODE) begin
                r2_year <= r1_year;
                r2_a    <= YEAR_START[r1_year];
            end else begin
                r2_year <= w_ysel;
                r2_a    <= YEAR_START[w_ysel];
            end
        end
    end

    // Stage 3
    logic        r3_dec;
    logic [31:0] r3_word;
    logic        r3_ovf;
    logic [8:0]  r3_rem;
    logic        r3_leap;
    logic [6:0]  r3_year;
    logic [16:0] r3_tod;
    logic [17:0] w_count, w_c;
    logic [16:0] w_rem;

    assign w_count = 18'(r2_a) + 18'(r2_ms) + 18'(r2_md);
    assign w_c     = w_count - 18'd1;
    assign w_rem   = 17'(r2_d) - r2_a;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_dec  <= r2_dec;
            r3_tod  <= r2_tod;
            r3_year <= r2_year[6:0];
            r3_leap <= YEAR_LEAP[r2_year];
            r3_rem  <= w_rem[8:0];
            r3_word <= {w_c[DAY_BITS-1:0], r2_tod};
            r3_ovf  <= (w_count == '0) || (w_c > 18'((1 << DAY_BITS) - 1));
        end
    end

    // Stage 4
    logic [3:0] w_mon;
    logic [8:0] w_mday;

    always_comb begin
        w_mon = '0;
        for (int k = 1; k < 12; k++) begin
            if (MONTH_START[r3_leap][k] <= r3_rem) begin
                w_mon = w_mon + 4'd1;
            end
        end
    end
    assign w_mday = r3_rem - MONTH_START[r3_leap][w_mon] + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r3_dec == REQ_ENCODE) begin
                o_word_out     <= r3_word;
                o_day_overflow <= r3_ovf;
                o_year_out     <= '0;
                o_month_out    <= '0;
                o_mday_out     <= '0;
                o_hour_out     <= '0;
                o_minute_out   <= '0;
                o_second_out   <= '0;
            end else begin
                o_word_out     <= '0;
                o_day_overflow <= 1'b0;
                o_year_out     <= r3_year;
                o_month_out    <= w_mon;
                o_mday_out     <= w_mday[4:0];
                o_hour_out     <= r3_tod[16:12];
                o_minute_out   <= r3_tod[11:6];
                o_second_out   <= r3_tod[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

`ifndef SYNTHESIS
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_month_out <= MONTH_MAX) else $error("month out of range");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("input stalled with empty output");
    a_encode_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word_out != '0) |-> (o_year_out == '0 && o_mday_out == '0))
        else $error("encode result carries date fields");
    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && i_stall) |=> $stable(r_v3)) else $error("pipeline moved under stall");
`endif
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for rtc_day_count_calendar_convert_core: encodes and decodes
// RTC counter words and compares each result against an in-bench calendar predictor.
// Depends on rtcdc_pkg and the core RTL.
`default_nettype none
module tb_top;
    import rtcdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_req        req;
        logic [6:0]  year;
        logic [7:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] word;
        int          gap;
        bit          drain;
    } t_date_req;

    typedef struct {
        logic [31:0] word;
        logic [6:0]  year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        ovf;
    } t_date_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [6:0]  i_year_in = '0;
    logic [7:0]  i_month_in = '0;
    logic [4:0]  i_mday_in = '0;
    logic [4:0]  i_hour_in = '0;
    logic [5:0]  i_minute_in = '0;
    logic [5:0]  i_second_in = '0;
    logic [31:0] i_word_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_word_out;
    logic [6:0]  o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_mday_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic        o_day_overflow;

    t_date_req pending_reqs[$];
    t_date_res expected_dates[$];
    int        gap_left = 0;
    int        hold_left = 0;
    int        n_encode = 0;
    int        n_decode = 0;
    int        n_results = 0;
    int        n_errors = 0;
    bit        quiet_rx = 1'b0;

    rtc_day_count_calendar_convert_core DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit is_leap(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_before_month(input bit leap, input int m);
        int norm[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        return norm[m] + ((leap && m >= 2) ? 1 : 0);
    endfunction

    function automatic t_date_res convert_date(input t_date_req r);
        t_date_res res;
        int yrs;
        int mon;
        int cnt;
        int d;
        int len;
        bit lp;
        res = '{default: '0};
        if (r.req == REQ_ENCODE) begin
            yrs = r.year + r.month / 12;
            mon = r.month % 12;
            cnt = 0;
            for (int y = 0; y < yrs; y++) cnt += is_leap(y + BASE_YEAR) ? 366 : 365;
            cnt += days_before_month(is_leap(yrs + BASE_YEAR), mon) + r.mday;
            if (cnt == 0) begin
                res.word[31:17] = '1;
                res.ovf = 1'b1;
            end else begin
                res.word[31:17] = 15'(cnt - 1);
                res.ovf = (cnt - 1) > 32767;
            end
            res.word[16:0] = {r.hour, r.minute, r.second};
        end else begin
            d = r.word[31:17];
            yrs = 0;
            forever begin
                len = is_leap(yrs + BASE_YEAR) ? 366 : 365;
                if (d < len) break;
                d -= len;
                yrs++;
            end
            lp = is_leap(yrs + BASE_YEAR);
            mon = 11;
            while (mon > 0 && days_before_month(lp, mon) > d) mon--;
            res.year = 7'(yrs);
            res.month = 4'(mon);
            res.mday = 5'(d - days_before_month(lp, mon) + 1);
            res.hour = r.word[16:12];
            res.minute = r.word[11:6];
            res.second = r.word[5:0];
        end
        return res;
    endfunction

    task automatic add_encode(input int y, input int m, input int md, input int h,
                              input int mi, input int s, input int gap);
        t_date_req r;
        r = '{req: REQ_ENCODE, year: 7'(y), month: 8'(m), mday: 5'(md), hour: 5'(h),
              minute: 6'(mi), second: 6'(s), word: $urandom, gap: gap, drain: 1'b0};
        pending_reqs.push_back(r);
    endtask

    task automatic add_decode(input logic [31:0] w, input int gap);
        t_date_req r;
        r = '{req: REQ_DECODE, year: 7'($urandom), month: 8'($urandom), mday: 5'($urandom),
              hour: 5'($urandom), minute: 6'($urandom), second: 6'($urandom), word: w,
              gap: gap, drain: 1'b0};
        pending_reqs.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(convert_date('{req: t_req'(i_req_type),
                    year: i_year_in, month: i_month_in, mday: i_mday_in, hour: i_hour_in,
                    minute: i_minute_in, second: i_second_in, word: i_word_in,
                    gap: 0, drain: 1'b0}));
                if (i_req_type == REQ_ENCODE) n_encode++;
                else n_decode++;
            end
            if (!(i_valid && o_stall)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].drain || expected_dates.size() == 0)) begin
                    t_date_req r;
                    r = pending_reqs.pop_front();
                    i_req_type <= r.req;
                    i_year_in <= r.year;
                    i_month_in <= r.month;
                    i_mday_in <= r.mday;
                    i_hour_in <= r.hour;
                    i_minute_in <= r.minute;
                    i_second_in <= r.second;
                    i_word_in <= r.word;
                    i_valid <= 1'b1;
                    gap_left <= r.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result transaction, word %h", o_word_out);
                    n_errors++;
                end else begin
                    t_date_res e;
                    e = expected_dates.pop_front();
                    if (o_word_out !== e.word) begin
                        $error("word_out expected %h actual %h", e.word, o_word_out);
                        n_errors++;
                    end
                    if (o_year_out !== e.year) begin
                        $error("year_out expected %0d actual %0d", e.year, o_year_out);
                        n_errors++;
                    end
                    if (o_month_out !== e.month) begin
                        $error("month_out expected %0d actual %0d", e.month, o_month_out);
                        n_errors++;
                    end
                    if (o_mday_out !== e.mday) begin
                        $error("mday_out expected %0d actual %0d", e.mday, o_mday_out);
                        n_errors++;
                    end
                    if (o_hour_out !== e.hour) begin
                        $error("hour_out expected %0d actual %0d", e.hour, o_hour_out);
                        n_errors++;
                    end
                    if (o_minute_out !== e.minute) begin
                        $error("minute_out expected %0d actual %0d", e.minute, o_minute_out);
                        n_errors++;
                    end
                    if (o_second_out !== e.second) begin
                        $error("second_out expected %0d actual %0d", e.second, o_second_out);
                        n_errors++;
                    end
                    if (o_day_overflow !== e.ovf) begin
                        $error("day_overflow expected %0d actual %0d", e.ovf, o_day_overflow);
                        n_errors++;
                    end
                end
                n_results++;
                if (n_results == 300) begin
                    hold_left <= 60;
                    i_stall <= 1'b1;
                end else begin
                    int s;
                    s = quiet_rx ? 0 : $urandom_range(0, 4);
                    hold_left <= s;
                    i_stall <= (s > 0);
                end
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= (hold_left > 1);
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int g;
        add_encode(0, 0, 0, 0, 0, 0, 0);
        add_encode(0, 0, 1, 0, 0, 0, 0);
        add_encode(127, 255, 31, 31, 63, 63, 0);
        add_encode(127, 11, 31, 23, 59, 59, 1);
        add_encode(89, 8, 18, 12, 30, 15, 0);
        add_encode(89, 8, 19, 0, 0, 0, 0);
        add_encode(0, 1, 29, 1, 2, 3, 2);
        add_encode(100, 1, 29, 4, 5, 6, 0);
        add_encode(4, 1, 29, 7, 8, 9, 0);
        add_encode(0, 12, 0, 0, 0, 0, 3);
        add_encode(99, 11, 31, 23, 59, 59, 0);
        add_encode(0, 1, 31, 0, 0, 0, 0);
        add_decode(32'h0000_0000, 0);
        add_decode(32'hFFFF_FFFF, 0);
        add_decode({15'd364, 17'h1_2345}, 1);
        add_decode({15'd365, 17'h0_0FFF}, 0);
        add_decode({15'd1519, 17'h0}, 0);
        add_decode({15'd1520, 17'h0}, 0);
        add_decode({15'd32506, 17'h1_FFFF}, 0);
        add_decode({15'd32507, 17'h0}, 2);
        add_decode({15'd32566, 17'h0}, 0);
        add_decode({15'd32767, 17'h0}, 0);
        pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
        for (int i = 0; i < 1100; i++) begin
            g = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 1)) add_decode($urandom, g);
            else if ($urandom_range(0, 3) == 0)
                add_encode($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, g);
            else
                add_encode($urandom_range(0, 89), $urandom_range(0, 11),
                           $urandom_range(1, 31), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59), g);
            if (i == 600) pending_reqs[pending_reqs.size() - 1].drain = 1'b1;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() > 0 || i_valid) begin
            @(posedge i_clk);
            quiet_rx = ((n_results / 150) % 3 == 1);
        end
        while (expected_dates.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Ran %0d encode and %0d decode transactions, %0d results checked.",
                 n_encode, n_decode, n_results);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/rtcdc_pkg.sv
src/rtc_day_count_calendar_convert_core.sv
sim/tb_top.sv
